### src/gyro_bias_scale_decimator_assert.svh
// Assertion macros shared by the gyro decimator modules.
// Each module that uses them names its clock i_clk and its reset i_rst_n.
`ifndef GYRO_BIAS_SCALE_DECIMATOR_ASSERT_SVH
`define GYRO_BIAS_SCALE_DECIMATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GBSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define GBSD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/gbsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbsd_pkg;

    localparam int NUM_AXES   = 3;
    localparam int SAMPLE_W   = 16;
    localparam int SCALE_W    = 24;
    localparam int WIN_W      = 8;
    localparam int SUM_W      = 24;
    localparam int RATE_W     = 32;
    localparam int FRAC_BITS  = 8;
    localparam int MUL_A_W    = SUM_W + 1;
    localparam int PROD_W     = MUL_A_W + SCALE_W + 1;
    localparam int DIVD_W     = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);
    localparam logic [WIN_W-1:0]   WIN_ONE   = WIN_W'(1);
    localparam logic signed [SAMPLE_W-1:0] SAT_HI = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAT_LO = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X,
        CFG_OFFSET_Y,
        CFG_OFFSET_Z,
        CFG_DPS_PER_LSB,
        CFG_WIN_LEN
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CAP,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] raw_x;
        logic signed [SAMPLE_W-1:0] raw_y;
        logic signed [SAMPLE_W-1:0] raw_z;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] comp_x;
        logic signed [SAMPLE_W-1:0] comp_y;
        logic signed [SAMPLE_W-1:0] comp_z;
        logic signed [RATE_W-1:0]   rate_x;
        logic signed [RATE_W-1:0]   rate_y;
        logic signed [RATE_W-1:0]   rate_z;
        logic signed [RATE_W-1:0]   avg_x;
        logic signed [RATE_W-1:0]   avg_y;
        logic signed [RATE_W-1:0]   avg_z;
        logic                       window_done;
    } t_out_item;

    typedef struct packed {
        logic                     start;
        logic signed [DIVD_W-1:0] dividend;
        logic [WIN_W-1:0]         divisor;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [RATE_W-1:0] quot;
    } t_div_rsp;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_W:0] v);
        logic signed [SAMPLE_W-1:0] res;
        if (v > SAMPLE_W'(SAT_HI)) begin
            res = SAT_HI;
        end else if (v < SAMPLE_W'(SAT_LO)) begin
            res = SAT_LO;
        end else begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### src/gbsd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gbsd_in_if;
    logic               valid;
    logic               ready;
    gbsd_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/gbsd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gbsd_out_if;
    logic                valid;
    logic                ready;
    gbsd_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/gbsd_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module gbsd_mul (
    input  wire logic                                   i_clk,
    input  wire logic signed [gbsd_pkg::MUL_A_W-1:0]    i_a,
    input  wire logic [gbsd_pkg::SCALE_W-1:0]           i_b,
    output logic signed [gbsd_pkg::PROD_W-1:0]          o_prod
);
    import gbsd_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    always_comb begin
        n_prod = PROD_W'(i_a) * PROD_W'($signed({1'b0, i_b}));
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;
endmodule

`default_nettype wire

### src/gbsd_div.sv
`timescale 1ns / 1ps
`default_nettype none

`include "gyro_bias_scale_decimator_assert.svh"

module gbsd_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gbsd_pkg::t_div_req i_req,
    output gbsd_pkg::t_div_rsp     o_rsp
);
    import gbsd_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVD_W - 1);

    logic               r_busy;
    logic               r_done;
    logic               r_neg;
    logic [DIVD_W-1:0]  r_quo;
    logic [WIN_W-1:0]   r_rem;
    logic [WIN_W-1:0]   r_dvs;
    logic [CNT_W-1:0]   r_cnt;

    logic [DIVD_W-1:0]  dvd_raw;
    logic [DIVD_W-1:0]  dvd_mag;
    logic [WIN_W:0]     rem_sh;
    logic [WIN_W:0]     rem_sub;
    logic               fits;
    logic [RATE_W-1:0]  quo_lo;

    always_comb begin
        dvd_raw = i_req.dividend;
        dvd_mag = dvd_raw[DIVD_W-1] ? (~dvd_raw + 1'b1) : dvd_raw;
        rem_sh  = {r_rem, r_quo[DIVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        fits    = (rem_sh >= {1'b0, r_dvs});
        quo_lo  = r_quo[RATE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_cnt == CNT_LAST)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= dvd_mag;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_neg <= dvd_raw[DIVD_W-1];
            r_cnt <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], fits};
            r_rem <= fits ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = $signed(r_neg ? (~quo_lo + 1'b1) : quo_lo);

    `GBSD_ASSERT_IMP(a_no_restart, i_req.start, !r_busy, "Divider started while busy.")
    `GBSD_ASSERT_IMP(a_done_ends_run, r_done, !r_busy && $past(r_busy), "Done without a run.")
    `GBSD_ASSERT_IMP(a_rem_bound, r_busy, r_rem < r_dvs, "Partial remainder out of range.")
endmodule

`default_nettype wire

### src/gyro_bias_scale_decimator.sv
// Three-axis gyro bias removal, scaling and boxcar decimation. Each request carries one raw
// sample and yields one result: the bias-corrected samples saturated to 16 bits, their rates
// in Q23.8 degrees per second, and, on the request that closes a window, the window average.
// A request that does not close a window makes three passes through the shared multiplier,
// each a multiply state and a capture state, then loads the output register and returns to
// the idle state, in which the next request is accepted.
// A request that closes a window adds three sum passes, each a multiply and capture followed
// by a 40-step division by the sample count through one shared restoring divider
// that produces one quotient bit per cycle. The input is not ready while a request is being
// worked on; a finished result waits in the output register and does not block acceptance,
// but the next result is held back until the previous one has been taken.
// Writing the window length register starts a new window.
`timescale 1ns / 1ps
`default_nettype none

`include "gyro_bias_scale_decimator_assert.svh"

module gyro_bias_scale_decimator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    gbsd_in_if.sink                                i_in_ch,
    gbsd_out_if.source                             o_out_ch,
    input  wire logic                              i_cfg_we,
    input  wire logic [gbsd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [gbsd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gbsd_pkg::*;

    localparam logic [2:0] STEP_LAST_RATE = 3'd2;
    localparam logic [2:0] STEP_FIRST_SUM = 3'd3;
    localparam logic [2:0] STEP_LAST      = 3'd5;

    t_state                       r_state;
    t_state                       n_state;
    logic [2:0]                   r_step;
    logic [2:0]                   n_step;

    logic signed [SAMPLE_W-1:0]   r_off [NUM_AXES];
    logic [SCALE_W-1:0]           r_scale;
    logic [WIN_W-1:0]             r_decim;
    logic signed [SUM_W-1:0]      r_sum [NUM_AXES];
    logic [WIN_W-1:0]             r_count;

    logic signed [SAMPLE_W-1:0]   r_comp [NUM_AXES];
    logic signed [RATE_W-1:0]     r_rate [NUM_AXES];
    logic signed [RATE_W-1:0]     r_avg  [NUM_AXES];
    logic                         r_done;
    logic [WIN_W-1:0]             r_n;
    logic                         r_out_valid;
    t_out_item                    r_out;

    logic signed [SAMPLE_W-1:0]   raw_in  [NUM_AXES];
    logic signed [SAMPLE_W-1:0]   comp_in [NUM_AXES];
    logic signed [SUM_W-1:0]      sum_in  [NUM_AXES];
    logic [WIN_W-1:0]             count_next;
    logic                         done_in;
    logic [SCALE_W-1:0]           eff_scale;
    logic [WIN_W-1:0]             eff_win;
    logic [2:0]                   step_m3;
    logic [1:0]                   sel;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [PROD_W-1:0]     prod;
    logic                         in_ready;
    logic                         accept;
    logic                         out_load;
    t_div_req                     div_req;
    t_div_rsp                     div_rsp;

    gbsd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (eff_scale),
        .o_prod (prod)
    );

    gbsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        raw_in[0] = i_in_ch.data.raw_x;
        raw_in[1] = i_in_ch.data.raw_y;
        raw_in[2] = i_in_ch.data.raw_z;
        for (int a = 0; a < NUM_AXES; a++) begin
            comp_in[a] = sat16((SAMPLE_W + 1)'(raw_in[a]) - (SAMPLE_W + 1)'(r_off[a]));
            sum_in[a]  = r_sum[a] + SUM_W'(comp_in[a]);
        end
        eff_scale  = (r_scale == '0) ? SCALE_ONE : r_scale;
        eff_win    = (r_decim == '0) ? WIN_ONE : r_decim;
        count_next = r_count + 1'b1;
        done_in    = (count_next >= eff_win);
        step_m3    = r_step - STEP_FIRST_SUM;
        sel        = (r_step > STEP_LAST_RATE) ? step_m3[1:0] : r_step[1:0];
        mul_a      = (r_step > STEP_LAST_RATE) ? MUL_A_W'(r_sum[sel]) : MUL_A_W'(r_comp[sel]);
    end

    always_comb begin
        n_state          = r_state;
        n_step           = r_step;
        in_ready         = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = prod[DIVD_W+FRAC_BITS-1:FRAC_BITS];
        div_req.divisor  = r_n;
        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in_ch.valid) begin
                    n_state = S_MUL;
                    n_step  = '0;
                end
            end
            S_MUL: begin
                n_state = S_CAP;
            end
            S_CAP: begin
                if (r_step > STEP_LAST_RATE) begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end else if ((r_step == STEP_LAST_RATE) && !r_done) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MUL;
                    n_step  = r_step + 1'b1;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (r_step == STEP_LAST) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MUL;
                        n_step  = r_step + 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_out_ch.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign accept = in_ready && i_in_ch.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_off[a] <= '0;
                r_sum[a] <= '0;
            end
            r_scale     <= SCALE_ONE;
            r_decim     <= WIN_ONE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_sum[a] <= sum_in[a];
                end
                r_count <= count_next;
            end
            if (out_load && r_done) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_sum[a] <= '0;
                end
                r_count <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OFFSET_X: begin
                        r_off[0] <= i_cfg_data[SAMPLE_W-1:0];
                    end
                    CFG_OFFSET_Y: begin
                        r_off[1] <= i_cfg_data[SAMPLE_W-1:0];
                    end
                    CFG_OFFSET_Z: begin
                        r_off[2] <= i_cfg_data[SAMPLE_W-1:0];
                    end
                    CFG_DPS_PER_LSB: begin
                        r_scale <= i_cfg_data[SCALE_W-1:0];
                    end
                    CFG_WIN_LEN: begin
                        r_decim <= i_cfg_data[WIN_W-1:0];
                        for (int a = 0; a < NUM_AXES; a++) begin
                            r_sum[a] <= '0;
                        end
                        r_count <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_comp[a] <= comp_in[a];
            end
            r_done <= done_in;
            r_n    <= count_next;
        end
        if ((r_state == S_CAP) && (r_step <= STEP_LAST_RATE)) begin
            r_rate[sel] <= prod[RATE_W+FRAC_BITS-1:FRAC_BITS];
        end
        if ((r_state == S_DIV) && div_rsp.done) begin
            r_avg[sel] <= div_rsp.quot;
        end
        if (out_load) begin
            r_out.comp_x      <= r_comp[0];
            r_out.comp_y      <= r_comp[1];
            r_out.comp_z      <= r_comp[2];
            r_out.rate_x      <= r_rate[0];
            r_out.rate_y      <= r_rate[1];
            r_out.rate_z      <= r_rate[2];
            r_out.avg_x       <= r_done ? r_avg[0] : '0;
            r_out.avg_y       <= r_done ? r_avg[1] : '0;
            r_out.avg_z       <= r_done ? r_avg[2] : '0;
            r_out.window_done <= r_done;
        end
    end

    assign i_in_ch.ready  = in_ready;
    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;

    `GBSD_ASSERT_NXT(a_accept_starts, accept, r_state == S_MUL, "Request did not start work.")
    `GBSD_ASSERT_IMP(a_div_done_waited, div_rsp.done, r_state == S_DIV, "Stray divider result.")
    `GBSD_ASSERT_IMP(a_count_in_window, r_state == S_IDLE, r_count < eff_win, "Window overrun.")
endmodule

`default_nettype wire
